### rtl/lightpath_wavelength_switch_table_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lightpath wavelength switch table.
// Both macros sample on i_clk and are disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LIGHTPATH_WAVELENGTH_SWITCH_TABLE_MACROS_SVH
`define LIGHTPATH_WAVELENGTH_SWITCH_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LWST_CHK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LWST_CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lwst_pkg.sv
// ----------------------------------------------------------------------------
// lwst_pkg
// Shared types, codes and defaults for the wavelength switch table.
// ----------------------------------------------------------------------------
`default_nettype none

package lwst_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    // Action codes of an input item.
    localparam logic [1:0] ACT_SETUP    = 2'd0;
    localparam logic [1:0] ACT_TEARDOWN = 2'd1;
    localparam logic [1:0] ACT_SWITCH   = 2'd2;
    localparam logic [1:0] ACT_NOP      = 2'd3;

    // Status codes of a result item.
    localparam logic [2:0] ST_FORWARDED = 3'd0;
    localparam logic [2:0] ST_DROPPED   = 3'd1;
    localparam logic [2:0] ST_STORED    = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_REMOVED   = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND = 3'd5;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] in_port;
        logic [7:0] in_wave;
        logic [7:0] out_port;
        logic [7:0] out_wave;
    } t_in;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] hop_port;
        logic [7:0] hop_wave;
        logic [6:0] entries_used;
    } t_out;

    typedef enum logic [1:0] {
        OP_SETUP,
        OP_TEARDOWN,
        OP_SWITCH
    } t_op;

    // A classified command handed from the front end to the table engine.
    typedef struct packed {
        t_op        op;
        logic [7:0] in_port;
        logic [7:0] in_wave;
        logic [7:0] out_port;
        logic [7:0] out_wave;
    } t_cmd;

endpackage

`default_nettype wire

### rtl/lwst_front.sv
// ----------------------------------------------------------------------------
// lwst_front
// Accepts input items, classifies the action and queues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module lwst_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire lwst_pkg::t_in i_item,
    output logic               o_cmd_valid,
    input  wire logic          i_cmd_ready,
    output lwst_pkg::t_cmd     o_cmd
);

    lwst_pkg::t_cmd r_q [2];
    logic [1:0]     r_cnt;
    logic           r_wptr;
    logic           r_rptr;

    lwst_pkg::t_cmd cls_cmd;
    logic           cls_keep;
    logic           q_push;
    logic           q_pop;

    // Unused action codes are accepted and dropped here.
    always_comb begin
        cls_cmd.in_port  = i_item.in_port;
        cls_cmd.in_wave  = i_item.in_wave;
        cls_cmd.out_port = i_item.out_port;
        cls_cmd.out_wave = i_item.out_wave;
        cls_keep         = 1'b1;
        case (i_item.action)
            lwst_pkg::ACT_SETUP:    cls_cmd.op = lwst_pkg::OP_SETUP;
            lwst_pkg::ACT_TEARDOWN: cls_cmd.op = lwst_pkg::OP_TEARDOWN;
            lwst_pkg::ACT_SWITCH:   cls_cmd.op = lwst_pkg::OP_SWITCH;
            default: begin
                cls_cmd.op = lwst_pkg::OP_SWITCH;
                cls_keep   = 1'b0;
            end
        endcase
    end

    assign full        = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rptr];
    assign q_push      = push && !full && cls_keep;
    assign q_pop       = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (q_push) begin
            r_q[r_wptr] <= cls_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
        end else begin
            if (q_push) begin
                r_wptr <= !r_wptr;
            end
            if (q_pop) begin
                r_rptr <= !r_rptr;
            end
            if (q_push && !q_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (q_pop && !q_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/lwst_engine.sv
// ----------------------------------------------------------------------------
// lwst_engine
// Holds the mapping table in a memory and carries out one command at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module lwst_engine #(
    parameter int TABLE_DEPTH = lwst_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cmd_valid,
    output logic                o_cmd_ready,
    input  wire lwst_pkg::t_cmd i_cmd,
    output logic                o_res_valid,
    input  wire logic           i_res_ready,
    output lwst_pkg::t_out      o_res
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW:0] DEPTH_X = (CW+1)'(TABLE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_RESULT
    } t_state;

    logic [31:0]      r_mem [TABLE_DEPTH];
    logic [31:0]      r_rdata;

    t_state           r_state, n_state;
    lwst_pkg::t_op    r_op, n_op;
    logic [31:0]      r_key, n_key;
    logic [AW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_count, n_count;
    logic [2:0]       r_status, n_status;
    logic [7:0]       r_np, n_np;
    logic [7:0]       r_nw, n_nw;

    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [31:0]      wr_data;
    logic [CW:0]      idx_p1;
    logic [CW:0]      idx_p2;
    logic [CW:0]      cnt_x;
    logic             hit;

    assign idx_p1 = (CW+1)'(r_idx) + (CW+1)'(1);
    assign idx_p2 = (CW+1)'(r_idx) + (CW+1)'(2);
    assign cnt_x  = (CW+1)'(r_count);

    // A switch matches on the input pair alone, a teardown on the whole entry.
    assign hit = (r_op == lwst_pkg::OP_SWITCH) ? (r_rdata[31:16] == r_key[31:16])
                                               : (r_rdata == r_key);

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_key    = r_key;
        n_idx    = r_idx;
        n_count  = r_count;
        n_status = r_status;
        n_np     = r_np;
        n_nw     = r_nw;
        rd_addr  = r_idx;
        wr_en    = 1'b0;
        wr_addr  = r_idx;
        wr_data  = r_rdata;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_op    = i_cmd.op;
                    n_key   = {i_cmd.in_port, i_cmd.in_wave, i_cmd.out_port, i_cmd.out_wave};
                    n_idx   = '0;
                    n_np    = 8'd0;
                    n_nw    = 8'd0;
                    rd_addr = '0;
                    n_state = S_RESULT;
                    case (i_cmd.op)
                        lwst_pkg::OP_SETUP: begin
                            if (cnt_x < DEPTH_X) begin
                                wr_en    = 1'b1;
                                wr_addr  = AW'(r_count);
                                wr_data  = n_key;
                                n_count  = r_count + CW'(1);
                                n_status = lwst_pkg::ST_STORED;
                            end else begin
                                n_status = lwst_pkg::ST_FULL;
                            end
                        end
                        lwst_pkg::OP_TEARDOWN: begin
                            n_status = lwst_pkg::ST_NOT_FOUND;
                            if (r_count != '0) begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_status = lwst_pkg::ST_DROPPED;
                            if (r_count != '0) begin
                                n_state = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (hit) begin
                    if (r_op == lwst_pkg::OP_SWITCH) begin
                        n_status = lwst_pkg::ST_FORWARDED;
                        n_np     = r_rdata[15:8];
                        n_nw     = r_rdata[7:0];
                        n_state  = S_RESULT;
                    end else if (idx_p1 < cnt_x) begin
                        // Later entries move up one place each.
                        rd_addr = AW'(idx_p1);
                        n_state = S_SHIFT;
                    end else begin
                        n_count  = r_count - CW'(1);
                        n_status = lwst_pkg::ST_REMOVED;
                        n_state  = S_RESULT;
                    end
                end else if (idx_p1 < cnt_x) begin
                    rd_addr = AW'(idx_p1);
                    n_idx   = AW'(idx_p1);
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = r_idx;
                wr_data = r_rdata;
                n_idx   = AW'(idx_p1);
                if (idx_p2 < cnt_x) begin
                    rd_addr = AW'(idx_p2);
                end else begin
                    n_count  = r_count - CW'(1);
                    n_status = lwst_pkg::ST_REMOVED;
                    n_state  = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= lwst_pkg::OP_SETUP;
            r_key    <= '0;
            r_idx    <= '0;
            r_count  <= '0;
            r_status <= lwst_pkg::ST_FORWARDED;
            r_np     <= 8'd0;
            r_nw     <= 8'd0;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_key    <= n_key;
            r_idx    <= n_idx;
            r_count  <= n_count;
            r_status <= n_status;
            r_np     <= n_np;
            r_nw     <= n_nw;
        end
    end

    assign o_cmd_ready        = (r_state == S_IDLE);
    assign o_res_valid        = (r_state == S_RESULT);
    assign o_res.status       = r_status;
    assign o_res.hop_port     = r_np;
    assign o_res.hop_wave     = r_nw;
    assign o_res.entries_used = 7'(r_count);

endmodule

`default_nettype wire

### rtl/lwst_resq.sv
// ----------------------------------------------------------------------------
// lwst_resq
// Two-place result queue between the table engine and the result port.
// ----------------------------------------------------------------------------
`default_nettype none

module lwst_resq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_res_valid,
    output logic                o_res_ready,
    input  wire lwst_pkg::t_out i_res,
    output logic                empty,
    input  wire logic           pop,
    output lwst_pkg::t_out      o_result
);

    lwst_pkg::t_out r_q [2];
    logic [1:0]     r_cnt;
    logic           r_wptr;
    logic           r_rptr;
    logic           q_push;
    logic           q_pop;

    assign o_res_ready = (r_cnt != 2'd2);
    assign empty       = (r_cnt == 2'd0);
    assign o_result    = r_q[r_rptr];
    assign q_push      = i_res_valid && o_res_ready;
    assign q_pop       = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (q_push) begin
            r_q[r_wptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
        end else begin
            if (q_push) begin
                r_wptr <= !r_wptr;
            end
            if (q_pop) begin
                r_rptr <= !r_rptr;
            end
            if (q_push && !q_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (q_pop && !q_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/lightpath_wavelength_switch_table.sv
// A setup, or any item on an empty table, goes from the engine's idle state straight to its
// result state; a switch or teardown first scans the entries in order, and a teardown then
// shifts the later entries up. The table engine handles one item at a time: it takes a command
// in its idle state and holds the result in its result state until the result queue takes it.
// Reset (synchronous, active low) empties the table and both queues; the table memory
// itself is not cleared, as only the first entries_used places are ever read.
// ----------------------------------------------------------------------------
// lightpath_wavelength_switch_table
// Wavelength cross-connect mapping table with setup, teardown and switch items.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lightpath_wavelength_switch_table_macros.svh"

module lightpath_wavelength_switch_table #(
    parameter int TABLE_DEPTH = lwst_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire lwst_pkg::t_in i_item,
    output logic               empty,
    input  wire logic          pop,
    output lwst_pkg::t_out     o_result
);

    // Commands travel from the front end to the engine through a two-place queue, so the input
    // side keeps taking items while the engine scans the table, until that queue is full.
    logic           cmd_valid;
    logic           cmd_ready;
    lwst_pkg::t_cmd cmd;

    // Finished results wait in the result queue, so the engine can start the
    // next item while the consumer holds off popping.
    logic           res_valid;
    logic           res_ready;
    lwst_pkg::t_out res;

    // Conditions watched by the checks at the end of the module.
    logic           res_not_fwd;
    logic           hop_zero;
    logic           status_ok;
    logic           item_kept;

    lwst_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    // The engine keeps entries packed in insertion order. Lookups scan from the
    // oldest entry, and a teardown moves every later entry up by one place.
    lwst_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    lwst_resq u_resq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .o_res_ready (res_ready),
        .i_res       (res),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

    assign res_not_fwd = !empty && (o_result.status != lwst_pkg::ST_FORWARDED);
    assign hop_zero    = (o_result.hop_port == 8'd0) && (o_result.hop_wave == 8'd0);
    assign status_ok   = (o_result.status <= lwst_pkg::ST_NOT_FOUND);
    assign item_kept   = push && !full && (i_item.action != lwst_pkg::ACT_NOP);

    // Only a forwarded packet carries a non-zero next hop.
    `LWST_CHK_NOW(a_hop_zero, res_not_fwd, hop_zero, "hop set on an unforwarded result")

    // Status codes stay within the defined set.
    `LWST_CHK_NOW(a_status_range, !empty, status_ok, "undefined status code")

    // A meaningful item accepted at the input is waiting for the engine next cycle.
    `LWST_CHK_NEXT(a_cmd_queued, item_kept, cmd_valid, "accepted item not queued")

endmodule

`default_nettype wire

### tb/lightpath_wavelength_switch_table_tb.sv
// ----------------------------------------------------------------------------
// lightpath_wavelength_switch_table_tb
// Self-checking bench for the wavelength switch table. Directed items cover the
// empty table, extreme field values, duplicate entries, earliest-match lookup
// and removal, misses and the unused action code. Random traffic then fills
// and drains the table with mostly well-formed setups, teardowns and switches.
// A local copy of the table predicts every result, and a checker compares each
// popped result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module lightpath_wavelength_switch_table_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH   = lwst_pkg::TABLE_DEPTH_DEF;
    localparam int MAX_REPORTS   = 10;
    // Worst case a teardown scans and moves the whole table, so the tail wait
    // after the last result must cover a full scan plus the queue stages.
    localparam int DRAIN_CYCLES  = 4 * TABLE_DEPTH + 50;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS   = 150;

    // One lightpath as held in the table, in the same field order as the block.
    typedef struct packed {
        logic [7:0] in_port;
        logic [7:0] in_wave;
        logic [7:0] out_port;
        logic [7:0] out_wave;
    } t_lightpath;

    logic           i_clk;
    logic           i_rst_n;
    logic           push;
    logic           full;
    lwst_pkg::t_in  i_item;
    logic           empty;
    logic           pop;
    lwst_pkg::t_out o_result;

    // Local copy of the table in insertion order, and the results still owed.
    t_lightpath     lightpaths[$];
    lwst_pkg::t_out pending_results[$];

    int n_errors;
    int n_results;
    // Sender pacing: burst length left and the longest gap between bursts.
    // A longest gap of zero gives a stretch with push held high throughout.
    int burst_left;
    int sender_max_gap;

    lightpath_wavelength_switch_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run: every item scanning and
    // shifting the whole table, waiting out the longest sender gap and the
    // longest receiver stall.
    initial begin
        #30ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Applies one item to the local table. Returns 0 for the unused action
    // code, which leaves the table alone and gives no result.
    function automatic bit predict_result(input lwst_pkg::t_in item,
                                          output lwst_pkg::t_out res);
        t_lightpath key;
        int         hit;
        key = {item.in_port, item.in_wave, item.out_port, item.out_wave};
        res = '0;
        hit = -1;
        case (item.action)
            lwst_pkg::ACT_SETUP: begin
                if (lightpaths.size() < TABLE_DEPTH) begin
                    lightpaths.push_back(key);
                    res.status = lwst_pkg::ST_STORED;
                end else begin
                    res.status = lwst_pkg::ST_FULL;
                end
            end
            lwst_pkg::ACT_TEARDOWN: begin
                // Both pairs must match; the earliest such entry goes and the
                // rest close up behind it.
                foreach (lightpaths[i]) begin
                    if (hit < 0 && lightpaths[i] == key) hit = i;
                end
                if (hit >= 0) begin
                    lightpaths.delete(hit);
                    res.status = lwst_pkg::ST_REMOVED;
                end else begin
                    res.status = lwst_pkg::ST_NOT_FOUND;
                end
            end
            lwst_pkg::ACT_SWITCH: begin
                // Only the input pair is compared; the output fields of the
                // item play no part.
                foreach (lightpaths[i]) begin
                    if (hit < 0 && lightpaths[i].in_port == key.in_port &&
                        lightpaths[i].in_wave == key.in_wave) hit = i;
                end
                if (hit >= 0) begin
                    res.status   = lwst_pkg::ST_FORWARDED;
                    res.hop_port = lightpaths[hit].out_port;
                    res.hop_wave = lightpaths[hit].out_wave;
                end else begin
                    res.status = lwst_pkg::ST_DROPPED;
                end
            end
            default: begin
                return 1'b0;
            end
        endcase
        res.entries_used = 7'(lightpaths.size());
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    function automatic void report_error(input string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS) $display("ERROR: %s", msg);
    endfunction

    function automatic void check_field(input string name, input int idx,
                                        input int expv, input int actv);
        if (expv != actv) begin
            report_error($sformatf("result %0d %s expected 0x%0h got 0x%0h",
                                   idx, name, expv, actv));
        end
    endfunction

    // A result is taken at a rising edge with pop high and empty low. The
    // outputs are read before the edge's updates land, so this sees the
    // values that the handshake actually moved.
    always @(posedge i_clk) begin
        lwst_pkg::t_out want;
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                report_error($sformatf("result %0d arrived with none expected: 0x%0h",
                                       n_results, o_result));
            end else begin
                want = pending_results.pop_front();
                check_field("status", n_results, want.status, o_result.status);
                check_field("hop_port", n_results, want.hop_port, o_result.hop_port);
                check_field("hop_wave", n_results, want.hop_wave, o_result.hop_wave);
                check_field("entries_used", n_results, want.entries_used,
                            o_result.entries_used);
            end
            n_results++;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver
    // ------------------------------------------------------------------------

    // The receiver moves between four stall patterns: always ready, a coin
    // toss each cycle, a fixed three-in-five rhythm, and long random stalls
    // broken by a single pop.
    initial begin
        int mode;
        int mode_left;
        int stall_left;
        int rhythm;
        pop        = 1'b0;
        mode       = 0;
        mode_left  = 0;
        stall_left = 0;
        rhythm     = 0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(50, 200);
            end
            mode_left--;
            rhythm = (rhythm + 1) % 5;
            case (mode)
                0: pop <= 1'b1;
                1: pop <= 1'($urandom_range(0, 1));
                2: pop <= (rhythm < 3);
                default: begin
                    if (stall_left == 0) begin
                        pop        <= 1'b1;
                        stall_left = $urandom_range(1, 16);
                    end else begin
                        pop <= 1'b0;
                        stall_left--;
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    function automatic lwst_pkg::t_in make_item(input logic [1:0] action,
                                                input logic [7:0] ip,
                                                input logic [7:0] iw,
                                                input logic [7:0] op,
                                                input logic [7:0] ow);
        lwst_pkg::t_in item;
        item.action   = action;
        item.in_port  = ip;
        item.in_wave  = iw;
        item.out_port = op;
        item.out_wave = ow;
        return item;
    endfunction

    // Presents one item from a falling edge and holds it until a rising edge
    // sees push high with full low. The prediction is made at that edge, so
    // the local table always reflects every item the block has taken. The
    // task waits for the next falling edge, where push is only lowered if a gap follows, and returns
    // after any such gap, so push is never dropped and raised in one time step.
    task automatic send_item(input lwst_pkg::t_in item);
        lwst_pkg::t_out res;
        i_item <= item;
        push   <= 1'b1;
        do @(posedge i_clk); while (full);
        if (predict_result(item, res)) pending_results.push_back(res);
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            if (sender_max_gap > 0) begin
                push <= 1'b0;
                repeat ($urandom_range(1, sender_max_gap)) @(negedge i_clk);
            end
            burst_left = $urandom_range(0, 40);
        end
    endtask

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // Nothing can match on an empty table.
    task automatic test_empty_table();
        send_item(make_item(lwst_pkg::ACT_SWITCH, 8'h12, 8'h34, 8'hff, 8'h00));
        send_item(make_item(lwst_pkg::ACT_TEARDOWN, 8'h12, 8'h34, 8'h56, 8'h78));
    endtask

    // The unused action code must pass through without a result or any
    // change to the table, whatever its other fields hold.
    task automatic test_ignored_action();
        send_item(make_item(lwst_pkg::ACT_NOP, 8'h00, 8'h00, 8'h00, 8'h00));
        send_item(make_item(lwst_pkg::ACT_NOP, 8'hff, 8'hff, 8'hff, 8'hff));
    endtask

    // Extreme values, an input pair with two different outputs and an exact
    // duplicate; a switch must always pick the earliest entry.
    task automatic test_setup_and_switch();
        send_item(make_item(lwst_pkg::ACT_SETUP, 8'h00, 8'h00, 8'h00, 8'h00));
        send_item(make_item(lwst_pkg::ACT_SETUP, 8'hff, 8'hff, 8'hff, 8'hff));
        send_item(make_item(lwst_pkg::ACT_SETUP, 8'haa, 8'h55, 8'h11, 8'h22));
        send_item(make_item(lwst_pkg::ACT_SETUP, 8'haa, 8'h55, 8'h33, 8'h44));
        send_item(make_item(lwst_pkg::ACT_SETUP, 8'haa, 8'h55, 8'h11, 8'h22));
        send_item(make_item(lwst_pkg::ACT_SWITCH, 8'h00, 8'h00, 8'hff, 8'hff));
        send_item(make_item(lwst_pkg::ACT_SWITCH, 8'hff, 8'hff, 8'h00, 8'h00));
        send_item(make_item(lwst_pkg::ACT_SWITCH, 8'haa, 8'h55, 8'h00, 8'h00));
        send_item(make_item(lwst_pkg::ACT_SWITCH, 8'haa, 8'hff, 8'h00, 8'h00));
    endtask

    // A teardown needs both pairs to match. Removing the earliest duplicate
    // must expose the next entry for the same input pair, and the entries
    // behind must close up in order.
    task automatic test_teardown();
        send_item(make_item(lwst_pkg::ACT_TEARDOWN, 8'haa, 8'h55, 8'h33, 8'h45));
        send_item(make_item(lwst_pkg::ACT_TEARDOWN, 8'haa, 8'h55, 8'h11, 8'h22));
        send_item(make_item(lwst_pkg::ACT_SWITCH, 8'haa, 8'h55, 8'h00, 8'h00));
        send_item(make_item(lwst_pkg::ACT_TEARDOWN, 8'haa, 8'h55, 8'h11, 8'h22));
        send_item(make_item(lwst_pkg::ACT_SWITCH, 8'haa, 8'h55, 8'h00, 8'h00));
        send_item(make_item(lwst_pkg::ACT_TEARDOWN, 8'hff, 8'hff, 8'hff, 8'hff));
        send_item(make_item(lwst_pkg::ACT_SWITCH, 8'hff, 8'hff, 8'hff, 8'hff));
        send_item(make_item(lwst_pkg::ACT_SWITCH, 8'h00, 8'h00, 8'h00, 8'h00));
    endtask

    // ------------------------------------------------------------------------
    // Random traffic
    // ------------------------------------------------------------------------

    // Builds one random item. Most fields come from a tiny value pool so that
    // duplicates and earliest-match cases are common; the rest use the full
    // range so that every bit toggles. Teardowns and switches mostly aim at
    // entries that are present, with a share of near misses and noise.
    function automatic lwst_pkg::t_in random_item(input int setup_pct);
        lwst_pkg::t_in item;
        t_lightpath    pick;
        int            roll;
        item = lwst_pkg::t_in'(34'({$urandom(), $urandom()}));
        if ($urandom_range(0, 99) < 3) begin
            item.action = lwst_pkg::ACT_NOP;
            return item;
        end
        if ($urandom_range(0, 99) < 70) begin
            item.in_port  = 8'($urandom_range(0, 3));
            item.in_wave  = 8'($urandom_range(0, 3));
            item.out_port = 8'($urandom_range(0, 3));
            item.out_wave = 8'($urandom_range(0, 3));
        end
        roll = $urandom_range(0, 99);
        if (roll < setup_pct) begin
            item.action = lwst_pkg::ACT_SETUP;
        end else begin
            item.action = roll[0] ? lwst_pkg::ACT_TEARDOWN : lwst_pkg::ACT_SWITCH;
            if (lightpaths.size() > 0 && $urandom_range(0, 99) < 65) begin
                pick          = lightpaths[$urandom_range(0, lightpaths.size() - 1)];
                item.in_port  = pick.in_port;
                item.in_wave  = pick.in_wave;
                if (item.action == lwst_pkg::ACT_TEARDOWN) begin
                    item.out_port = pick.out_port;
                    item.out_wave = pick.out_wave;
                    // Right input pair but a wrong output pair must not match.
                    if ($urandom_range(0, 99) < 20) begin
                        item.out_wave[$urandom_range(0, 7)] ^= 1'b1;
                    end
                end
            end
        end
        return item;
    endfunction

    // Phases cycle between a filling mix that runs the table into its full
    // state, a balanced mix, and a draining mix that empties it again. Some
    // phases send back to back with no gaps at all.
    task automatic test_random_traffic();
        int setup_pct;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase % 3)
                0:       setup_pct = 90;
                1:       setup_pct = 50;
                default: setup_pct = 15;
            endcase
            sender_max_gap = (phase % 4 == 1) ? 0 : 20;
            repeat (PHASE_ITEMS) send_item(random_item(setup_pct));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial begin
        i_rst_n        = 1'b0;
        push           = 1'b0;
        i_item         = '0;
        n_errors       = 0;
        n_results      = 0;
        burst_left     = 0;
        sender_max_gap = 6;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_table();
        test_ignored_action();
        test_setup_and_switch();
        test_teardown();
        test_random_traffic();

        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // Let any stray result from a late item show itself to the checker.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/lwst_pkg.sv
rtl/lwst_front.sv
rtl/lwst_engine.sv
rtl/lwst_resq.sv
rtl/lightpath_wavelength_switch_table.sv
tb/lightpath_wavelength_switch_table_tb.sv
